### design/dti_pkg.sv
// ----------------------------------------------------------------------------
// Distance table interpolator package
// Shared item, configuration and result types and fixed-point constants.
// ----------------------------------------------------------------------------
package dti_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_TABLE_COUNT = 1'b0;
  localparam logic REG_INV_HUBBLE  = 1'b1;

  localparam int unsigned MIN_ENTRIES = 3;

  localparam logic signed [63:0] SAT_LIM    = 64'sh2000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q24    = 64'sd16777216;
  localparam logic signed [63:0] Z_CAP      = 64'sd17179869184;
  localparam logic signed [63:0] RECIP_X    = 64'sd2147483648;
  localparam logic signed [63:0] SCALE_2P20 = 64'sd1048576;
  localparam logic signed [63:0] SCALE_2P38 = 64'sd274877906944;

  typedef enum logic [1:0] {MD_DIVIDE, MD_SHIFT20, MD_SHIFT24} md_mode_e;

  typedef struct packed {
    logic        kind;
    logic [9:0]  entry_index;
    logic [31:0] redshift_value;
    logic [31:0] distance_value;
    logic [31:0] scale_factor;
  } item_t;

  typedef struct packed {
    logic [10:0] table_count;
    logic [31:0] inv_hubble_distance;
  } cfg_t;

  typedef struct packed {
    logic [31:0] distance_out;
    logic [47:0] slope_out;
    logic        out_of_range;
  } result_t;

endpackage

### design/distance_table_interpolator.sv
// A load item writes one (redshift, distance) entry into the table and
// returns nothing. A query item returns one result: the interpolated
// distance, the slope over the scale factor and a flag for queries outside
// the table span. Items are processed one at a time, and a query runs on
// the shared 64-bit multiply-divide unit: of its nine operations in
// sequence, six divide by a data value with four 32x32 partial products
// and 64 one-bit division steps, and three divide by a power of two and
// finish with a shift. Each binary search step reads a table entry and
// then compares it, and a fetch pass then reads eight table entries. An
// operation with a zero divisor ends early and one that saturates skips
// the division steps. Table entries hold no value until loaded and there
// is no clearing pass.
// ----------------------------------------------------------------------------
// Distance table interpolator top level
// Configuration registers, front end, item queue and back end.
// ----------------------------------------------------------------------------
module distance_table_interpolator import dti_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] redshift_value_i,
  input  logic [31:0] distance_value_i,
  input  logic [31:0] scale_factor_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] distance_out_o,
  output logic [47:0] slope_out_o,
  output logic        out_of_range_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [10:0] TC_RESET  = 11'd1024;
  localparam logic [31:0] IHD_RESET = 32'd1432669;

  cfg_t    cfg_q;
  logic    q_wr_en, q_rd_en, q_empty, res_valid;
  item_t   q_wr_item, q_rd_item;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INV_HUBBLE) ? cfg_q.inv_hubble_distance :
                  {21'd0, cfg_q.table_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_count         <= TC_RESET;
      cfg_q.inv_hubble_distance <= IHD_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TABLE_COUNT) begin
        cfg_q.table_count <= pwdata[10:0];
      end else begin
        cfg_q.inv_hubble_distance <= pwdata;
      end
    end
  end

  dti_front u_front (
    .push             (push),
    .kind_i           (kind_i),
    .entry_index_i    (entry_index_i),
    .redshift_value_i (redshift_value_i),
    .distance_value_i (distance_value_i),
    .scale_factor_i   (scale_factor_i),
    .wr_en_o          (q_wr_en),
    .wr_item_o        (q_wr_item)
  );

  dti_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr_en),
    .wr_item_i (q_wr_item),
    .full_o    (full),
    .rd_en_i   (q_rd_en),
    .rd_item_o (q_rd_item),
    .empty_o   (q_empty)
  );

  dti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (q_rd_item),
    .empty_i     (q_empty),
    .rd_en_o     (q_rd_en),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign empty          = !res_valid;
  assign distance_out_o = res.distance_out;
  assign slope_out_o    = res.slope_out;
  assign out_of_range_o = res.out_of_range;

endmodule

### design/dti_front.sv
// ----------------------------------------------------------------------------
// Distance table interpolator front end
// Classifies incoming items, drops loads beyond the table and fixes zero scale.
// ----------------------------------------------------------------------------
module dti_front import dti_pkg::*; (
  input  logic        push,
  input  logic        kind_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] redshift_value_i,
  input  logic [31:0] distance_value_i,
  input  logic [31:0] scale_factor_i,
  output logic        wr_en_o,
  output item_t       wr_item_o
);

  logic [31:0] idx_ext;
  logic        drop;

  assign idx_ext = 32'(entry_index_i);
  assign drop    = (kind_i == KIND_LOAD) && (idx_ext >= 32'(TABLE_DEPTH));
  assign wr_en_o = push && !drop;

  always_comb begin
    wr_item_o.kind           = kind_i;
    wr_item_o.entry_index    = entry_index_i;
    wr_item_o.redshift_value = redshift_value_i;
    wr_item_o.distance_value = distance_value_i;
    wr_item_o.scale_factor   = (scale_factor_i == 32'd0) ? 32'd1 : scale_factor_i;
  end

endmodule

### design/dti_queue.sv
// ----------------------------------------------------------------------------
// Distance table interpolator item queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dti_queue import dti_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  item_t wr_item_i,
  output logic  full_o,
  input  logic  rd_en_i,
  output item_t rd_item_o,
  output logic  empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          wr_do, rd_do;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign rd_item_o = slots_q[rd_ptr_q];
  assign wr_do     = wr_en_i && !full_o;
  assign rd_do     = rd_en_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr_do) begin
      slots_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_do) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_do) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_do && !rd_do) begin
        count_q <= count_q + 1'b1;
      end else if (rd_do && !wr_do) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### design/dti_muldiv.sv
// ----------------------------------------------------------------------------
// Distance table interpolator multiply-divide unit
// Computes trunc(x*y/d) with saturation, one quotient bit per cycle, or with a
// single shift when d is a fixed power of two.
// ----------------------------------------------------------------------------
module dti_muldiv import dti_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  md_mode_e           mode_i,
  input  logic signed [63:0] x_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] d_i,
  output logic               done_o,
  output logic signed [63:0] q_o
);

  typedef enum logic [2:0] {M_IDLE, M_MUL, M_CHK, M_DIV, M_FIN} mstate_e;

  mstate_e      state_q;
  md_mode_e     mode_q;
  logic         neg_q;
  logic [63:0]  ux_q, uy_q, ud_q;
  logic [127:0] acc_q;
  logic [5:0]   cnt_q;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  trial, trial_n;
  logic         ge;
  logic [63:0]  quo;
  logic [63:0]  shr;

  always_comb begin
    pa = cnt_q[1] ? ux_q[63:32] : ux_q[31:0];
    pb = cnt_q[0] ? uy_q[63:32] : uy_q[31:0];
    pp = pa * pb;
    unique case (cnt_q[1:0])
      2'b00:   pp_sh = 128'(pp);
      2'b11:   pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    trial   = {acc_q[127:64], acc_q[63]};
    ge      = trial >= {1'b0, ud_q};
    trial_n = ge ? trial - {1'b0, ud_q} : trial;
    quo     = (acc_q[63:0] > SAT_LIM) ? SAT_LIM : acc_q[63:0];
    unique case (mode_q)
      MD_SHIFT20: shr = acc_q[83:20];
      MD_SHIFT24: shr = acc_q[87:24];
      default:    shr = acc_q[63:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      mode_q  <= MD_DIVIDE;
      done_o  <= 1'b0;
      q_o     <= '0;
      neg_q   <= 1'b0;
      ux_q    <= '0;
      uy_q    <= '0;
      ud_q    <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            mode_q <= mode_i;
            neg_q  <= (x_i[63] ^ y_i[63]) ^ d_i[63];
            ux_q   <= x_i[63] ? 64'd0 - x_i : x_i;
            uy_q   <= y_i[63] ? 64'd0 - y_i : y_i;
            ud_q   <= d_i[63] ? 64'd0 - d_i : d_i;
            acc_q  <= '0;
            cnt_q  <= '0;
            if (d_i == '0) begin
              q_o    <= '0;
              done_o <= 1'b1;
            end else begin
              state_q <= M_MUL;
            end
          end
        end
        M_MUL: begin
          acc_q <= acc_q + pp_sh;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'b11) begin
            state_q <= M_CHK;
          end
        end
        M_CHK: begin
          cnt_q <= '0;
          if (acc_q[127:64] >= ud_q) begin
            acc_q[63:0] <= SAT_LIM;
            state_q     <= M_FIN;
          end else if (mode_q == MD_DIVIDE) begin
            state_q <= M_DIV;
          end else begin
            acc_q[63:0] <= shr;
            state_q     <= M_FIN;
          end
        end
        M_DIV: begin
          acc_q <= {trial_n[63:0], acc_q[62:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd63) begin
            state_q <= M_FIN;
          end
        end
        M_FIN: begin
          q_o     <= neg_q ? 64'sd0 - $signed(quo) : $signed(quo);
          done_o  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

endmodule

### design/dti_back.sv
// ----------------------------------------------------------------------------
// Distance table interpolator back end
// Holds the table, runs the segment search and sequences the arithmetic.
// ----------------------------------------------------------------------------
module dti_back import dti_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    empty_i,
  output logic    rd_en_o,
  output result_t res_o,
  output logic    res_valid_o,
  input  logic    res_pop_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] SL_FIRST = 3'd0;
  localparam logic [2:0] SL_LAST  = 3'd1;
  localparam logic [2:0] SL_J     = 3'd2;
  localparam logic [2:0] SL_J1    = 3'd3;
  localparam logic [2:0] SL_U0    = 3'd4;
  localparam logic [2:0] SL_U1    = 3'd5;
  localparam logic [2:0] SL_L0    = 3'd6;
  localparam logic [2:0] SL_L1    = 3'd7;
  localparam logic [3:0] FETCH_LAST = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_OP, ST_SRCH_RD, ST_SRCH_CMP, ST_FETCH, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_RECIP, OP_DY, OP_DIST, OP_DOUT, OP_UP, OP_DOWN, OP_BLEND, OP_T, OP_SOUT
  } op_e;

  function automatic logic signed [63:0] ext(input logic [31:0] v);
    ext = $signed({32'd0, v});
  endfunction

  function automatic logic [31:0] sat_u32(input logic signed [63:0] v);
    if (v[63]) begin
      sat_u32 = '0;
    end else if (|v[62:32]) begin
      sat_u32 = '1;
    end else begin
      sat_u32 = v[31:0];
    end
  endfunction

  function automatic logic [47:0] sat_u48(input logic signed [63:0] v);
    if (v[63]) begin
      sat_u48 = '0;
    end else if (|v[62:48]) begin
      sat_u48 = '1;
    end else begin
      sat_u48 = v[47:0];
    end
  endfunction

  logic [31:0] z_mem [TABLE_DEPTH];
  logic [31:0] d_mem [TABLE_DEPTH];
  logic [31:0] rd_z_q, rd_d_q;
  logic [AW-1:0] rd_addr, wr_addr;

  state_e        state_q;
  op_e           op_q;
  logic [3:0]    fcnt_q;
  logic [AW-1:0] ilo_q, ihi_q;
  logic [NW-1:0] n_q;
  logic          md_start_q;
  logic          res_valid_q;

  logic [31:0]        a_q;
  logic signed [35:0] zq_q;
  logic signed [63:0] dy_q, dist_q, up_q, down_q, blend_q, t_q;
  logic [31:0]        dout_q;
  logic [47:0]        sout_q;
  logic [31:0]        fz_q [8];
  logic [31:0]        fd_q [8];
  result_t            res_q;

  logic               take, is_query, out_load, search_more, z_gt, up_ok;
  logic [31:0]        tc32, n32;
  logic [NW-1:0]      n_clamped, jn, n_m1;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid, fetch_addr;
  logic [2:0]         slot_w;
  logic signed [63:0] zq_ext, zq_full;
  logic signed [63:0] md_x, md_y, md_d, md_q;
  md_mode_e           md_mode;
  logic               md_done;
  op_e                next_op;

  assign take     = (state_q == ST_IDLE) && !empty_i;
  assign is_query = (item_i.kind == KIND_QUERY);
  assign rd_en_o  = take;
  assign out_load = (state_q == ST_OUT) && (!res_valid_q || res_pop_i);

  assign tc32      = 32'(cfg_i.table_count);
  assign n32       = (tc32 < MIN_ENTRIES) ? 32'(MIN_ENTRIES) :
                     (tc32 > TABLE_DEPTH) ? 32'(TABLE_DEPTH) : tc32;
  assign n_clamped = n32[NW-1:0];
  assign n_m1      = n_q - NW'(1);
  assign jn        = NW'(ilo_q);
  assign up_ok     = (jn + NW'(2)) <= n_m1;

  assign mid_sum     = (AW+1)'(ilo_q) + (AW+1)'(ihi_q);
  assign mid         = mid_sum[AW:1];
  assign search_more = (AW+1)'(ihi_q) > ((AW+1)'(ilo_q) + (AW+1)'(1));
  assign zq_ext      = {{28{zq_q[35]}}, zq_q};
  assign z_gt        = ext(rd_z_q) > zq_ext;
  assign zq_full     = md_q - ONE_Q24;
  assign slot_w      = 3'(fcnt_q - 4'd1);
  assign wr_addr     = AW'(32'(item_i.entry_index));

  always_comb begin
    unique case (fcnt_q[2:0])
      SL_FIRST: fetch_addr = '0;
      SL_LAST:  fetch_addr = n_m1[AW-1:0];
      SL_J:     fetch_addr = ilo_q;
      SL_J1:    fetch_addr = ilo_q + 1'b1;
      SL_U0:    fetch_addr = up_ok ? ilo_q : AW'(n_q - NW'(2));
      SL_U1:    fetch_addr = up_ok ? AW'(jn + NW'(2)) : n_m1[AW-1:0];
      SL_L0:    fetch_addr = (ilo_q != '0) ? ilo_q - 1'b1 : ilo_q;
      SL_L1:    fetch_addr = ilo_q + 1'b1;
      default:  fetch_addr = '0;
    endcase
    rd_addr = (state_q == ST_FETCH) ? fetch_addr : mid;
  end

  always_comb begin
    md_mode = MD_DIVIDE;
    unique case (op_q)
      OP_RECIP: begin md_x = RECIP_X; md_y = ONE_Q24; md_d = ext(a_q); end
      OP_DY: begin
        md_x = zq_ext - ext(fz_q[SL_J]);
        md_y = ONE_Q24;
        md_d = ext(fz_q[SL_J1]) - ext(fz_q[SL_J]);
      end
      OP_DIST: begin
        md_x    = dy_q;
        md_y    = ext(fd_q[SL_J1]) - ext(fd_q[SL_J]);
        md_d    = ONE_Q24;
        md_mode = MD_SHIFT24;
      end
      OP_DOUT: begin
        md_x    = dist_q;
        md_y    = ext(cfg_i.inv_hubble_distance);
        md_d    = SCALE_2P20;
        md_mode = MD_SHIFT20;
      end
      OP_UP: begin
        md_x = ext(fd_q[SL_U1]) - ext(fd_q[SL_U0]);
        md_y = ONE_Q24;
        md_d = ext(fz_q[SL_U1]) - ext(fz_q[SL_U0]);
      end
      OP_DOWN: begin
        md_x = ext(fd_q[SL_L1]) - ext(fd_q[SL_L0]);
        md_y = ONE_Q24;
        md_d = ext(fz_q[SL_L1]) - ext(fz_q[SL_L0]);
      end
      OP_BLEND: begin
        md_x    = dy_q;
        md_y    = up_q - down_q;
        md_d    = ONE_Q24;
        md_mode = MD_SHIFT24;
      end
      OP_T: begin
        md_x = blend_q; md_y = ext(cfg_i.inv_hubble_distance); md_d = ext(a_q);
      end
      OP_SOUT: begin md_x = t_q; md_y = SCALE_2P38; md_d = ext(a_q); end
      default: begin md_x = '0; md_y = '0; md_d = '0; end
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_DY:    next_op = OP_DIST;
      OP_DIST:  next_op = OP_DOUT;
      OP_DOUT:  next_op = OP_UP;
      OP_UP:    next_op = OP_DOWN;
      OP_DOWN:  next_op = OP_BLEND;
      OP_BLEND: next_op = OP_T;
      OP_T:     next_op = OP_SOUT;
      default:  next_op = OP_DY;
    endcase
  end

  dti_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start_q),
    .mode_i  (md_mode),
    .x_i     (md_x),
    .y_i     (md_y),
    .d_i     (md_d),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  always_ff @(posedge clk_i) begin
    if (take && !is_query) begin
      z_mem[wr_addr] <= item_i.redshift_value;
      d_mem[wr_addr] <= item_i.distance_value;
    end
    rd_z_q <= z_mem[rd_addr];
    rd_d_q <= d_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take && is_query) begin
      a_q <= item_i.scale_factor;
    end
    if (state_q == ST_FETCH && fcnt_q != 4'd0) begin
      fz_q[slot_w] <= rd_z_q;
      fd_q[slot_w] <= rd_d_q;
    end
    if (state_q == ST_OP && md_done) begin
      unique case (op_q)
        OP_RECIP: zq_q <= (zq_full > Z_CAP) ? Z_CAP[35:0] : zq_full[35:0];
        OP_DY:    dy_q <= md_q;
        OP_DIST:  dist_q <= ext(fd_q[SL_J]) + md_q;
        OP_DOUT:  dout_q <= sat_u32(md_q);
        OP_UP:    up_q <= md_q;
        OP_DOWN:  down_q <= md_q;
        OP_BLEND: blend_q <= down_q + md_q;
        OP_T:     t_q <= md_q;
        OP_SOUT:  sout_q <= sat_u48(md_q);
        default:  t_q <= md_q;
      endcase
    end
    if (out_load) begin
      res_q.distance_out <= dout_q;
      res_q.slope_out    <= sout_q;
      res_q.out_of_range <= (zq_ext < ext(fz_q[SL_FIRST])) ||
                            (zq_ext > ext(fz_q[SL_LAST]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_RECIP;
      fcnt_q      <= '0;
      ilo_q       <= '0;
      ihi_q       <= '0;
      n_q         <= '0;
      md_start_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      md_start_q <= 1'b0;
      if (res_valid_q && res_pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take && is_query) begin
            n_q        <= n_clamped;
            op_q       <= OP_RECIP;
            md_start_q <= 1'b1;
            state_q    <= ST_OP;
          end
        end
        ST_OP: begin
          if (md_done) begin
            if (op_q == OP_RECIP) begin
              ilo_q   <= '0;
              ihi_q   <= n_m1[AW-1:0];
              state_q <= ST_SRCH_RD;
            end else if (op_q == OP_SOUT) begin
              state_q <= ST_OUT;
            end else begin
              op_q       <= next_op;
              md_start_q <= 1'b1;
            end
          end
        end
        ST_SRCH_RD: begin
          if (search_more) begin
            state_q <= ST_SRCH_CMP;
          end else begin
            fcnt_q  <= '0;
            state_q <= ST_FETCH;
          end
        end
        ST_SRCH_CMP: begin
          if (z_gt) begin
            ihi_q <= mid;
          end else begin
            ilo_q <= mid;
          end
          state_q <= ST_SRCH_RD;
        end
        ST_FETCH: begin
          if (fcnt_q == FETCH_LAST) begin
            op_q       <= OP_DY;
            md_start_q <= 1'b1;
            state_q    <= ST_OP;
          end else begin
            fcnt_q <= fcnt_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

### design/dti_checker.sv
// ----------------------------------------------------------------------------
// Distance table interpolator checker
// Port-level assertions on results and configuration readback.
// ----------------------------------------------------------------------------
module dti_checker import dti_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] distance_out_o,
  input logic [47:0] slope_out_o,
  input logic        out_of_range_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(distance_out_o) &&
                          $stable(slope_out_o) && $stable(out_of_range_o)))
    else $error("Waiting result changed before it was taken.");

  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("Result vanished without being taken.");

  a_ihd_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[2] == REG_INV_HUBBLE)) |=>
      ((paddr[2] != REG_INV_HUBBLE) || (prdata == $past(pwdata))))
    else $error("Inverse Hubble distance readback mismatch.");

  a_tc_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[2] == REG_TABLE_COUNT)) |=>
      ((paddr[2] != REG_TABLE_COUNT) || (prdata == {21'd0, $past(pwdata[10:0])})))
    else $error("Table count readback mismatch.");

endmodule

bind distance_table_interpolator dti_checker u_dti_checker (.*);

### dv/distance_table_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance table interpolator testbench
// Loads redshift and distance tables through the item port and sends scale
// factor queries, checked against a local predictor or a fixed result. Table
// size and distance scale are changed between phases through the APB port.
// ----------------------------------------------------------------------------
module distance_table_interpolator_test;
  import dti_pkg::*;

  localparam int DEPTH = 1024;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 1000;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        kind_i;
  logic [9:0]  entry_index_i;
  logic [31:0] redshift_value_i;
  logic [31:0] distance_value_i;
  logic [31:0] scale_factor_i;
  logic        empty;
  logic        pop;
  logic [31:0] distance_out_o;
  logic [47:0] slope_out_o;
  logic        out_of_range_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] z_table [DEPTH];
  logic [31:0] d_table [DEPTH];
  logic [10:0] count_q;
  logic [31:0] inv_h_q;
  result_t     pending_results[$];
  step_t       directed_steps[$];
  int          fail_count;
  int          stall_cycles;
  bit          quiet_send;
  bit          quiet_recv;
  bit          hold_req;

  distance_table_interpolator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .entry_index_i   (entry_index_i),
    .redshift_value_i(redshift_value_i),
    .distance_value_i(distance_value_i),
    .scale_factor_i  (scale_factor_i),
    .empty           (empty),
    .pop             (pop),
    .distance_out_o  (distance_out_o),
    .slope_out_o     (slope_out_o),
    .out_of_range_o  (out_of_range_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint scaled_quotient(longint x, longint y, longint d);
    logic [63:0]  ux;
    logic [63:0]  uy;
    logic [63:0]  ud;
    logic [127:0] q;
    bit           neg;
    if (d == 0) return 0;
    neg = ((x < 0) != (y < 0)) != (d < 0);
    ux = (x < 0) ? 64'(-x) : 64'(x);
    uy = (y < 0) ? 64'(-y) : 64'(y);
    ud = (d < 0) ? 64'(-d) : 64'(d);
    q = ({64'd0, ux} * {64'd0, uy}) / {64'd0, ud};
    if (q > 128'(SAT_LIM)) q = 128'(SAT_LIM);
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint z_at(int k);
    return longint'({32'd0, z_table[k]});
  endfunction

  function automatic longint d_at(int k);
    return longint'({32'd0, d_table[k]});
  endfunction

  function automatic longint segment_gradient(int k0, int k1);
    return scaled_quotient(d_at(k1) - d_at(k0), ONE_Q24, z_at(k1) - z_at(k0));
  endfunction

  function automatic int entries_in_use();
    int n;
    n = count_q;
    if (n < MIN_ENTRIES) n = MIN_ENTRIES;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic result_t predict_query(logic [31:0] sf);
    int      n;
    int      lo;
    int      hi;
    int      mid;
    int      j;
    longint  a;
    longint  zq;
    longint  dy;
    longint  interp;
    longint  v;
    longint  up;
    longint  down;
    longint  blend;
    longint  t;
    longint  inv_h;
    result_t r;
    n = entries_in_use();
    inv_h = longint'({32'd0, inv_h_q});
    a = (sf == 0) ? 1 : longint'({32'd0, sf});
    zq = ((longint'(1) << 55) / a) - ONE_Q24;
    if (zq > Z_CAP) zq = Z_CAP;
    lo = 0;
    hi = n - 1;
    while (hi > lo + 1) begin
      mid = (lo + hi) / 2;
      if (z_at(mid) > zq) hi = mid;
      else lo = mid;
    end
    j = lo;
    r.out_of_range = (zq < z_at(0)) || (zq > z_at(n - 1));
    dy = scaled_quotient(zq - z_at(j), ONE_Q24, z_at(j + 1) - z_at(j));
    interp = d_at(j) + scaled_quotient(dy, d_at(j + 1) - d_at(j), ONE_Q24);
    v = scaled_quotient(interp, inv_h, SCALE_2P20);
    r.distance_out = (v < 0) ? 32'd0 : ((v > 64'hFFFF_FFFF) ? '1 : v[31:0]);
    up = (j + 2 <= n - 1) ? segment_gradient(j, j + 2) : segment_gradient(n - 2, n - 1);
    down = (j > 0) ? segment_gradient(j - 1, j + 1) : segment_gradient(j, j + 1);
    blend = down + scaled_quotient(dy, up - down, ONE_Q24);
    t = scaled_quotient(blend, inv_h, a);
    v = scaled_quotient(t, SCALE_2P38, a);
    r.slope_out = (v < 0) ? 48'd0 : ((v > 64'hFFFF_FFFF_FFFF) ? '1 : v[47:0]);
    return r;
  endfunction

  function automatic step_t load_row(logic [9:0] idx, logic [31:0] z, logic [31:0] d);
    step_t s;
    s.it = '{kind: KIND_LOAD, entry_index: idx, redshift_value: z, distance_value: d,
             scale_factor: 32'd0};
    s.typed = 1'b0;
    s.res = '0;
    return s;
  endfunction

  function automatic step_t query_row(logic [31:0] sf, bit typed, result_t res);
    step_t s;
    s.it = '{kind: KIND_QUERY, entry_index: 10'd0, redshift_value: 32'd0,
             distance_value: 32'd0, scale_factor: sf};
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t res);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push             <= 1'b1;
    kind_i           <= it.kind;
    entry_index_i    <= it.entry_index;
    redshift_value_i <= it.redshift_value;
    distance_value_i <= it.distance_value;
    scale_factor_i   <= it.scale_factor;
    do @(posedge clk_i); while (full);
    if (it.kind == KIND_LOAD) begin
      z_table[it.entry_index] = it.redshift_value;
      d_table[it.entry_index] = it.distance_value;
    end else begin
      pending_results.push_back(typed ? res : predict_query(it.scale_factor));
    end
  endtask

  task automatic write_reg(logic sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_TABLE_COUNT) count_q = value[10:0];
    else inv_h_q = value;
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic fill_table(int first, int last);
    longint z;
    longint d;
    item_t  it;
    z = (first == 0) ? $urandom_range(0, 1 << 22) : z_at(first - 1);
    d = (first == 0) ? $urandom_range(0, 1 << 20) : d_at(first - 1);
    for (int k = first; k <= last; k++) begin
      z += $urandom_range(1, 1 << 20);
      d += $urandom_range(1, 1 << 20);
      it = '{kind: KIND_LOAD, entry_index: k[9:0], redshift_value: z[31:0],
             distance_value: d[31:0], scale_factor: 32'd0};
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic random_items(int count, bit with_hold);
    int     n;
    int     r;
    longint lo;
    longint hi;
    longint zt;
    item_t  it;
    n = entries_in_use();
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 8) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      it.kind           = KIND_QUERY;
      it.entry_index    = 10'($urandom);
      it.redshift_value = $urandom;
      it.distance_value = $urandom;
      it.scale_factor   = $urandom;
      if (r < 70) begin
        lo = z_at(0);
        hi = z_at(n - 1);
        zt = (hi > lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
        it.scale_factor = 32'((longint'(1) << 55) / (zt + ONE_Q24));
      end else if (r < 75) begin
        case ($urandom_range(0, 3))
          0: it.scale_factor = 32'd0;
          1: it.scale_factor = 32'd1;
          2: it.scale_factor = 32'h8000_0000;
          default: it.scale_factor = 32'hFFFF_FFFF;
        endcase
      end else if (r < 90) begin
        it.kind = KIND_LOAD;
        if (n < DEPTH) it.entry_index = 10'($urandom_range(n, DEPTH - 1));
      end else begin
        it.kind = KIND_LOAD;
        it.entry_index = 10'($urandom_range(0, n - 1));
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(string what, result_t exp, result_t act);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected dist %h slope %h flag %b, got dist %h slope %h flag %b",
               what, exp.distance_out, exp.slope_out, exp.out_of_range,
               act.distance_out, act.slope_out, act.out_of_range);
    end
  endtask

  initial begin
    result_t got;
    result_t exp;
    int      gap;
    pop = 1'b0;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = quiet_recv ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (!rst_ni || empty);
      got = '{distance_out: distance_out_o, slope_out: slope_out_o,
              out_of_range: out_of_range_o};
      if (pending_results.size() == 0) begin
        report_mismatch("Unexpected result", '0, got);
      end else begin
        exp = pending_results.pop_front();
        if (got.distance_out !== exp.distance_out || got.slope_out !== exp.slope_out ||
            got.out_of_range !== exp.out_of_range) begin
          report_mismatch("Result mismatch", exp, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [10:0] counts [6];
    logic [31:0] scales [6];
    result_t     flagged;
    result_t     zeros;
    bit          full_loaded;
    int          n;
    rst_ni = 1'b0;
    push = 1'b0;
    kind_i = KIND_LOAD;
    entry_index_i = '0;
    redshift_value_i = '0;
    distance_value_i = '0;
    scale_factor_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    stall_cycles = 0;
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    hold_req = 1'b0;
    full_loaded = 1'b0;
    count_q = 11'd1024;
    inv_h_q = 32'd1432669;
    for (int k = 0; k < DEPTH; k++) begin
      z_table[k] = '0;
      d_table[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A table count of zero acts as three entries; distances start at zero.
    write_reg(REG_TABLE_COUNT, 32'd0);
    zeros = '{distance_out: 32'd0, slope_out: 48'd0, out_of_range: 1'b0};
    flagged = '{distance_out: 32'd0, slope_out: 48'd0, out_of_range: 1'b1};
    directed_steps.push_back(load_row(10'd0, 32'd0, 32'd0));
    directed_steps.push_back(load_row(10'd1, 32'h0100_0000, 32'd0));
    directed_steps.push_back(load_row(10'd2, 32'h0200_0000, 32'd0));
    directed_steps.push_back(query_row(32'h8000_0000, 1'b1, zeros));
    directed_steps.push_back(query_row(32'd0, 1'b1, flagged));
    directed_steps.push_back(query_row(32'd1, 1'b1, flagged));
    directed_steps.push_back(query_row(32'hFFFF_FFFF, 1'b1, flagged));
    directed_steps.push_back(load_row(10'd1, 32'h0100_0000, 32'h0064_0000));
    directed_steps.push_back(load_row(10'd2, 32'h0200_0000, 32'hFFFF_FFFF));
    directed_steps.push_back(query_row(32'h8000_0000, 1'b0, '0));
    directed_steps.push_back(query_row(32'h6000_0000, 1'b0, '0));
    directed_steps.push_back(query_row(32'h4000_0000, 1'b0, '0));
    directed_steps.push_back(query_row(32'h2000_0000, 1'b0, '0));
    directed_steps.push_back(query_row(32'd0, 1'b0, '0));
    directed_steps.push_back(query_row(32'hFFFF_FFFF, 1'b0, '0));
    directed_steps.push_back(load_row(10'd2, 32'h0100_0000, 32'd0));
    directed_steps.push_back(query_row(32'h4000_0000, 1'b0, '0));
    directed_steps.push_back(query_row(32'h5000_0000, 1'b0, '0));
    directed_steps.push_back(load_row(10'd1, 32'hFFFF_FFFF, 32'h8000_0000));
    directed_steps.push_back(query_row(32'h5555_5555, 1'b0, '0));
    directed_steps.push_back(load_row(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    foreach (directed_steps[i]) begin
      send_item(directed_steps[i].it, directed_steps[i].typed, directed_steps[i].res);
    end
    drain_and_settle();

    counts = '{11'd3, 11'd4, 11'd2047, 11'd1024, 11'd17, 11'd40};
    scales = '{32'd0, 32'hFFFF_FFFF, 32'd1432669, $urandom, $urandom, 32'h8000_0000};
    for (int p = 0; p < 6; p++) begin
      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_recv = ($urandom_range(0, 3) == 0);
      write_reg(REG_TABLE_COUNT, {21'd0, counts[p]});
      write_reg(REG_INV_HUBBLE, scales[p]);
      n = entries_in_use();
      if (n <= 64) begin
        fill_table(0, n - 1);
      end else if (!full_loaded) begin
        fill_table(0, DEPTH - 1);
        full_loaded = 1'b1;
      end
      random_items(50, p == 1);
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
